[rtl/bpg_pkg.sv]
`timescale 1ns / 1ps

package bpg_pkg;

	// Field and register widths
	localparam int RAW_W = 13;
	localparam int MV_W = 16;
	localparam int PCT_W = 7;
	localparam int POINT_W = 23;
	localparam int CFG_IDX_W = 3;
	localparam int FULL_POINTS = 6;

	// Parameter defaults
	localparam int HISTORY_DEPTH_DEF = 8;
	localparam int TABLE_POINTS_DEF = 6;

	// Shared multiplier: 16 x 13 bits
	localparam int PROD_W = MV_W + RAW_W;

	// Shared divider: 32 / 16, four quotient bits per cycle
	localparam int DIV_N_W = 32;
	localparam int DIV_D_W = 16;
	localparam int DIV_STEP = 4;
	localparam int DIV_ITERS = DIV_N_W / DIV_STEP;
	localparam int DIV_CNT_W = $clog2(DIV_ITERS);

	localparam logic [MV_W-1:0] MV_MAX = '1;
	localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;
	localparam logic [PCT_W-1:0] PCT_EMPTY = 7'd0;

	// Register reset values
	localparam logic [MV_W-1:0] MULT_RST = 16'd2;
	localparam logic [MV_W-1:0] DIVISOR_RST = 16'd1;
	localparam logic [FULL_POINTS-1:0][POINT_W-1:0] POINT_RST = {
		23'd3300, 23'd658960, 23'd1969830, 23'd3608330, 23'd5246880, 23'd6557800
	};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SCALE_MULT,
		REG_SCALE_DIV,
		REG_POINT_0,
		REG_POINT_1,
		REG_POINT_2,
		REG_POINT_3,
		REG_POINT_4,
		REG_POINT_5
	} reg_idx_t;

	typedef struct packed {
		logic [MV_W-1:0] mult;
		logic [MV_W-1:0] divisor;
		logic [FULL_POINTS-1:0][POINT_W-1:0] point;
	} cfg_t;

	typedef enum logic [1:0] {
		DIV_SCALE,
		DIV_INTERP
	} div_sel_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SMUL,
		S_SDIV,
		S_SWAIT,
		S_SCALE,
		S_FILL,
		S_RD,
		S_UPD,
		S_AVG,
		S_SEG,
		S_IMUL,
		S_IDIV,
		S_IWAIT,
		S_FIN,
		S_OUT
	} state_t;

	typedef struct packed {
		logic take_in;
		logic mul_scale;
		logic mul_interp;
		logic div_start;
		div_sel_t div_sel;
		logic take_scale;
		logic fill;
		logic ring_read;
		logic ring_update;
		logic avg_load;
		logic seg_load;
		logic fin;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic div_busy;
		logic div_done;
		logic fill_last;
		logic seg_direct;
	} status_t;

	function automatic logic [MV_W-1:0] point_mv(input logic [POINT_W-1:0] p);
		return p[MV_W-1:0];
	endfunction

	function automatic logic [PCT_W-1:0] point_pct(input logic [POINT_W-1:0] p);
		return p[POINT_W-1:MV_W];
	endfunction

endpackage

[rtl/bpg_intf.sv]
`timescale 1ns / 1ps

interface bpg_sample_if;
	logic valid;
	logic ready;
	logic [bpg_pkg::RAW_W-1:0] reading_mv;

	modport source (output valid, output reading_mv, input ready);
	modport sink (input valid, input reading_mv, output ready);
endinterface

interface bpg_result_if;
	logic valid;
	logic ready;
	logic [bpg_pkg::PCT_W-1:0] charge_percent;
	logic [bpg_pkg::MV_W-1:0] latest_scaled_mv;

	modport source (output valid, output charge_percent, output latest_scaled_mv, input ready);
	modport sink (input valid, input charge_percent, input latest_scaled_mv, output ready);
endinterface

interface bpg_cfg_if;
	logic valid;
	logic ready;
	logic [bpg_pkg::CFG_IDX_W-1:0] index;
	logic [bpg_pkg::POINT_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/bpg_ram.sv]
`timescale 1ns / 1ps

module bpg_ram #(
	parameter int WIDTH = bpg_pkg::MV_W,
	parameter int DEPTH = bpg_pkg::HISTORY_DEPTH_DEF,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/bpg_div.sv]
`timescale 1ns / 1ps

module bpg_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [bpg_pkg::DIV_N_W-1:0] dividend,
	input  logic [bpg_pkg::DIV_D_W-1:0] divisor,
	output logic                        busy,
	output logic                        done,
	output logic [bpg_pkg::DIV_N_W-1:0] quotient
);

	logic [bpg_pkg::DIV_N_W-1:0]   dvd_q;
	logic [bpg_pkg::DIV_D_W-1:0]   dsr_q;
	logic [bpg_pkg::DIV_D_W-1:0]   rem_q;
	logic [bpg_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                          busy_q;
	logic                          done_q;

	logic [bpg_pkg::DIV_N_W-1:0]   dvd_nxt;
	logic [bpg_pkg::DIV_D_W-1:0]   rem_nxt;
	logic [bpg_pkg::DIV_D_W:0]     trial;

	// Restoring division; quotient bits shift in at the bottom of the dividend
	always_comb begin
		dvd_nxt = dvd_q;
		rem_nxt = rem_q;
		trial = '0;
		for (int k = 0; k < bpg_pkg::DIV_STEP; k++) begin
			trial = {rem_nxt, dvd_nxt[bpg_pkg::DIV_N_W-1]};
			dvd_nxt = {dvd_nxt[bpg_pkg::DIV_N_W-2:0], 1'b0};
			if (trial >= {1'b0, dsr_q}) begin
				trial = trial - {1'b0, dsr_q};
				dvd_nxt[0] = 1'b1;
			end
			rem_nxt = trial[bpg_pkg::DIV_D_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == bpg_pkg::DIV_CNT_W'(bpg_pkg::DIV_ITERS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_nxt;
			rem_q <= rem_nxt;
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quotient = dvd_q;

endmodule

[rtl/bpg_dp.sv]
`timescale 1ns / 1ps

module bpg_dp #(
	parameter int HISTORY_DEPTH = bpg_pkg::HISTORY_DEPTH_DEF,
	parameter int TABLE_POINTS = bpg_pkg::TABLE_POINTS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  bpg_pkg::cmd_t             cmd,
	output bpg_pkg::status_t          status,
	input  bpg_pkg::cfg_t             cfg,
	input  logic [bpg_pkg::RAW_W-1:0] reading_mv,
	output logic [bpg_pkg::PCT_W-1:0] charge_percent,
	output logic [bpg_pkg::MV_W-1:0]  latest_scaled_mv
);

	localparam int PTR_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
	localparam int SUM_W = bpg_pkg::MV_W + $clog2(HISTORY_DEPTH);
	localparam int LAST = TABLE_POINTS - 1;
	localparam int MV_W = bpg_pkg::MV_W;
	localparam int PCT_W = bpg_pkg::PCT_W;

	// Average by reciprocal multiply: ceil(2^AVG_SH / depth) gives the exact floor
	// for every sum the ring can hold
	localparam int RCP_W = SUM_W + 1;
	localparam int AVG_SH = SUM_W + $clog2(HISTORY_DEPTH);
	localparam int APROD_W = SUM_W + RCP_W;
	localparam logic [RCP_W-1:0] AVG_RCP =
		RCP_W'(((64'd1 << AVG_SH) + 64'(HISTORY_DEPTH - 1)) / 64'(HISTORY_DEPTH));

	logic [bpg_pkg::RAW_W-1:0]   raw_q;
	logic [bpg_pkg::PROD_W-1:0]  prod_q;
	logic [MV_W-1:0]             v_q;
	logic [SUM_W-1:0]            sum_q;
	logic [PTR_W-1:0]            wp_q;
	logic [CNT_W-1:0]            fill_cnt_q;
	logic [MV_W-1:0]             avg_q;
	logic [MV_W-1:0]             off_q;
	logic [MV_W-1:0]             span_q;
	logic [PCT_W-1:0]            pl_q;
	logic [PCT_W-1:0]            pdiff_q;
	logic                        rise_q;
	logic [PCT_W-1:0]            pct_q;
	logic [PCT_W-1:0]            pct_out_q;
	logic [MV_W-1:0]             mv_out_q;

	logic [MV_W-1:0]             mul_a;
	logic [bpg_pkg::RAW_W-1:0]   mul_b;
	logic [bpg_pkg::DIV_N_W-1:0] div_n;
	logic [bpg_pkg::DIV_D_W-1:0] div_d;
	logic [bpg_pkg::DIV_N_W-1:0] quot;
	logic                        div_busy;
	logic                        div_done;

	logic [PTR_W-1:0]            wp_nxt;
	logic                        ram_we;
	logic [PTR_W-1:0]            ram_waddr;
	logic [MV_W-1:0]             ram_rdata;

	logic [APROD_W-1:0]          avg_prod;
	logic [MV_W-1:0]             avg;
	logic [MV_W-1:0]             seg_vh;
	logic [MV_W-1:0]             seg_vl;
	logic [PCT_W-1:0]            seg_ph;
	logic [PCT_W-1:0]            seg_pl;
	logic                        seg_found;
	logic                        seg_top;
	logic                        seg_bottom;

	logic [PCT_W:0]              q8;
	logic [PCT_W:0]              r8;

	// Shared multiplier: scale product, then interpolation product
	assign mul_a = cmd.mul_interp ? off_q : cfg.mult;
	assign mul_b = cmd.mul_interp ? bpg_pkg::RAW_W'(pdiff_q) : raw_q;

	assign avg_prod = APROD_W'(sum_q) * APROD_W'(AVG_RCP);

	always_ff @(posedge clk) begin
		if (cmd.take_in) begin
			raw_q <= reading_mv;
		end
		if (cmd.mul_scale || cmd.mul_interp) begin
			prod_q <= bpg_pkg::PROD_W'(mul_a) * bpg_pkg::PROD_W'(mul_b);
		end
		if (cmd.avg_load) begin
			avg_q <= avg_prod[AVG_SH +: MV_W];
		end
	end

	always_comb begin
		div_n = bpg_pkg::DIV_N_W'(prod_q);
		div_d = cfg.divisor;
		case (cmd.div_sel)
			bpg_pkg::DIV_SCALE: begin
				div_n = bpg_pkg::DIV_N_W'(prod_q);
				div_d = cfg.divisor;
			end
			bpg_pkg::DIV_INTERP: begin
				div_n = bpg_pkg::DIV_N_W'(prod_q);
				div_d = span_q;
			end
			default: begin
				div_n = bpg_pkg::DIV_N_W'(prod_q);
				div_d = cfg.divisor;
			end
		endcase
	end

	bpg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_n),
		.divisor  (div_d),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (quot)
	);

	// Saturate the scaled reading; a zero divisor reads as full scale
	always_ff @(posedge clk) begin
		if (cmd.take_scale) begin
			if (cfg.divisor == '0 || |quot[bpg_pkg::DIV_N_W-1:MV_W]) begin
				v_q <= bpg_pkg::MV_MAX;
			end else begin
				v_q <= quot[MV_W-1:0];
			end
		end
	end

	// History ring
	assign wp_nxt = (wp_q == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : wp_q + 1'b1;
	assign ram_we = cmd.fill || cmd.ring_update;
	assign ram_waddr = cmd.fill ? fill_cnt_q[PTR_W-1:0] : wp_q;

	bpg_ram #(
		.WIDTH (MV_W),
		.DEPTH (HISTORY_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (v_q),
		.re    (cmd.ring_read),
		.raddr (wp_nxt),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			wp_q <= '0;
			fill_cnt_q <= '0;
		end else begin
			if (cmd.fill) begin
				sum_q <= sum_q + SUM_W'(v_q);
				fill_cnt_q <= fill_cnt_q + 1'b1;
			end
			if (cmd.ring_read) begin
				wp_q <= wp_nxt;
			end
			if (cmd.ring_update) begin
				sum_q <= sum_q - SUM_W'(ram_rdata) + SUM_W'(v_q);
			end
		end
	end

	// Segment search over the breakpoints in use; the highest segment wins
	assign avg = avg_q;

	always_comb begin
		seg_found = 1'b0;
		seg_vh = bpg_pkg::point_mv(cfg.point[0]);
		seg_vl = bpg_pkg::point_mv(cfg.point[1]);
		seg_ph = bpg_pkg::point_pct(cfg.point[0]);
		seg_pl = bpg_pkg::point_pct(cfg.point[1]);
		for (int i = bpg_pkg::FULL_POINTS - 2; i >= 0; i--) begin
			if (i < LAST) begin
				if (avg <= bpg_pkg::point_mv(cfg.point[i]) &&
						avg > bpg_pkg::point_mv(cfg.point[i+1])) begin
					seg_found = 1'b1;
					seg_vh = bpg_pkg::point_mv(cfg.point[i]);
					seg_vl = bpg_pkg::point_mv(cfg.point[i+1]);
					seg_ph = bpg_pkg::point_pct(cfg.point[i]);
					seg_pl = bpg_pkg::point_pct(cfg.point[i+1]);
				end
			end
		end
	end

	assign seg_top = avg >= bpg_pkg::point_mv(cfg.point[0]);
	assign seg_bottom = avg <= bpg_pkg::point_mv(cfg.point[LAST]);

	// Finish the interpolation: rising or falling percent within the segment
	assign q8 = quot[PCT_W:0];

	always_comb begin
		if (rise_q) begin
			r8 = {1'b0, pl_q} + q8;
		end else if (q8 >= {1'b0, pl_q}) begin
			r8 = '0;
		end else begin
			r8 = {1'b0, pl_q} - q8;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.seg_load) begin
			pct_q <= seg_top ? bpg_pkg::PCT_FULL : bpg_pkg::PCT_EMPTY;
			off_q <= avg - seg_vl;
			span_q <= seg_vh - seg_vl;
			pl_q <= seg_pl;
			rise_q <= seg_ph >= seg_pl;
			pdiff_q <= (seg_ph >= seg_pl) ? seg_ph - seg_pl : seg_pl - seg_ph;
		end
		if (cmd.fin) begin
			pct_q <= (r8 > {1'b0, bpg_pkg::PCT_FULL}) ? bpg_pkg::PCT_FULL : r8[PCT_W-1:0];
		end
		if (cmd.load_out) begin
			pct_out_q <= pct_q;
			mv_out_q <= v_q;
		end
	end

	assign status.div_busy = div_busy;
	assign status.div_done = div_done;
	assign status.fill_last = fill_cnt_q == CNT_W'(HISTORY_DEPTH - 1);
	assign status.seg_direct = seg_top || seg_bottom || !seg_found;

	assign charge_percent = pct_out_q;
	assign latest_scaled_mv = mv_out_q;

endmodule

[rtl/bpg_ctrl.sv]
`timescale 1ns / 1ps

module bpg_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             sample_valid,
	output logic             sample_ready,
	output logic             result_valid,
	input  logic             result_ready,
	output bpg_pkg::cmd_t    cmd,
	input  bpg_pkg::status_t status
);

	bpg_pkg::state_t state_q;
	bpg_pkg::state_t state_d;
	logic            primed_q;
	logic            out_valid_q;
	logic            out_free;

	assign out_free = !out_valid_q || result_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			bpg_pkg::S_IDLE: begin
				if (sample_valid) state_d = bpg_pkg::S_SMUL;
			end
			bpg_pkg::S_SMUL:  state_d = bpg_pkg::S_SDIV;
			bpg_pkg::S_SDIV:  state_d = bpg_pkg::S_SWAIT;
			bpg_pkg::S_SWAIT: begin
				if (status.div_done) state_d = bpg_pkg::S_SCALE;
			end
			bpg_pkg::S_SCALE: state_d = primed_q ? bpg_pkg::S_RD : bpg_pkg::S_FILL;
			bpg_pkg::S_FILL: begin
				if (status.fill_last) state_d = bpg_pkg::S_AVG;
			end
			bpg_pkg::S_RD:    state_d = bpg_pkg::S_UPD;
			bpg_pkg::S_UPD:   state_d = bpg_pkg::S_AVG;
			bpg_pkg::S_AVG:   state_d = bpg_pkg::S_SEG;
			bpg_pkg::S_SEG:   state_d = status.seg_direct ? bpg_pkg::S_OUT : bpg_pkg::S_IMUL;
			bpg_pkg::S_IMUL:  state_d = bpg_pkg::S_IDIV;
			bpg_pkg::S_IDIV:  state_d = bpg_pkg::S_IWAIT;
			bpg_pkg::S_IWAIT: begin
				if (status.div_done) state_d = bpg_pkg::S_FIN;
			end
			bpg_pkg::S_FIN:   state_d = bpg_pkg::S_OUT;
			bpg_pkg::S_OUT: begin
				if (out_free) state_d = bpg_pkg::S_IDLE;
			end
			default:          state_d = bpg_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.div_sel = bpg_pkg::DIV_SCALE;
		case (state_q)
			bpg_pkg::S_IDLE:  cmd.take_in = sample_valid;
			bpg_pkg::S_SMUL:  cmd.mul_scale = 1'b1;
			bpg_pkg::S_SDIV:  cmd.div_start = 1'b1;
			bpg_pkg::S_SCALE: cmd.take_scale = 1'b1;
			bpg_pkg::S_FILL:  cmd.fill = 1'b1;
			bpg_pkg::S_RD:    cmd.ring_read = 1'b1;
			bpg_pkg::S_UPD:   cmd.ring_update = 1'b1;
			bpg_pkg::S_AVG:   cmd.avg_load = 1'b1;
			bpg_pkg::S_SEG:   cmd.seg_load = 1'b1;
			bpg_pkg::S_IMUL:  cmd.mul_interp = 1'b1;
			bpg_pkg::S_IDIV: begin
				cmd.div_start = 1'b1;
				cmd.div_sel = bpg_pkg::DIV_INTERP;
			end
			bpg_pkg::S_FIN:   cmd.fin = 1'b1;
			bpg_pkg::S_OUT:   cmd.load_out = out_free;
			default:          cmd.take_in = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bpg_pkg::S_IDLE;
			primed_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == bpg_pkg::S_FILL && status.fill_last) begin
				primed_q <= 1'b1;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sample_ready = state_q == bpg_pkg::S_IDLE;
	assign result_valid = out_valid_q;

	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !status.div_busy)
		else $error("divider restarted while busy");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || result_ready))
		else $error("output register overwritten before its beat was taken");

	a_primed_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(primed_q))
		else $error("primed flag dropped");

	a_fill_once: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fill |-> !primed_q)
		else $error("history fill after priming");

	a_update_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ring_update |-> $past(cmd.ring_read))
		else $error("ring update without its read");

endmodule

[rtl/battery_percent_gauge.sv]
// Path: when the average falls inside a segment, the result goes through the interpolation;
//   when it lands on or beyond either end of the table or between unordered points, the interpolation is skipped.
// The first reading after reset fills every ring entry instead of reading and updating a single entry.
// One reading at a time: the next beat is taken in the cycle after the result loads, and the
//   divider runs once to scale each reading and, inside a segment, once more to interpolate.
// Reset (arst_n low, asynchronous): clear control state and reload register defaults.
`timescale 1ns / 1ps

module battery_percent_gauge #(
	parameter int HISTORY_DEPTH = bpg_pkg::HISTORY_DEPTH_DEF,
	parameter int TABLE_POINTS = bpg_pkg::TABLE_POINTS_DEF
) (
	input logic          clk,
	input logic          arst_n,
	bpg_sample_if.sink   sample,
	bpg_result_if.source result,
	bpg_cfg_if.sink      cfg
);

	// Configuration registers. Writes must land only while the gauge is idle; the block itself
	// does not enforce this. They feed the datapath directly with no shadow copy.
	bpg_pkg::cfg_t    cfg_q;

	// Controller and datapath talk only through these two groups
	bpg_pkg::cmd_t    cmd;
	bpg_pkg::status_t status;

	// The register file never stalls a write beat
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mult <= bpg_pkg::MULT_RST;
			cfg_q.divisor <= bpg_pkg::DIVISOR_RST;
			cfg_q.point <= bpg_pkg::POINT_RST;
		end else if (cfg.valid) begin
			// Each breakpoint packs millivolts low and percent high
			case (bpg_pkg::reg_idx_t'(cfg.index))
				bpg_pkg::REG_SCALE_MULT: cfg_q.mult <= cfg.data[bpg_pkg::MV_W-1:0];
				bpg_pkg::REG_SCALE_DIV:  cfg_q.divisor <= cfg.data[bpg_pkg::MV_W-1:0];
				bpg_pkg::REG_POINT_0:    cfg_q.point[0] <= cfg.data;
				bpg_pkg::REG_POINT_1:    cfg_q.point[1] <= cfg.data;
				bpg_pkg::REG_POINT_2:    cfg_q.point[2] <= cfg.data;
				bpg_pkg::REG_POINT_3:    cfg_q.point[3] <= cfg.data;
				bpg_pkg::REG_POINT_4:    cfg_q.point[4] <= cfg.data;
				bpg_pkg::REG_POINT_5:    cfg_q.point[5] <= cfg.data;
				default:                 cfg_q.mult <= cfg_q.mult;
			endcase
		end
	end

	// Sequencer: accept a beat, scale it, update the ring (fill it on the first
	// reading), average, search the table, interpolate inside a segment, park the result.
	bpg_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample.valid),
		.sample_ready (sample.ready),
		.result_valid (result.valid),
		.result_ready (result.ready),
		.cmd          (cmd),
		.status       (status)
	);

	// Datapath: shared multiplier and divider, history ring, breakpoint search,
	// and the output register that holds a finished beat while the next
	// reading is already being accepted.
	bpg_dp #(
		.HISTORY_DEPTH (HISTORY_DEPTH),
		.TABLE_POINTS  (TABLE_POINTS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.status           (status),
		.cfg              (cfg_q),
		.reading_mv       (sample.reading_mv),
		.charge_percent   (result.charge_percent),
		.latest_scaled_mv (result.latest_scaled_mv)
	);

endmodule
